// File: sv/ulpc_pkg.sv
`default_nettype none

package ulpc_pkg;

  // characters seen by the command front end
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_O  = 8'h4F;
  localparam logic [7:0] CH_UC_N  = 8'h4E;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_P  = 8'h50;
  localparam logic [7:0] CH_UC_W  = 8'h57;
  localparam logic [7:0] CH_UC_M  = 8'h4D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UC_S  = 8'h53;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_S  = 8'h73;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_PER_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERCENT         = 2'd1;
  localparam logic [9:0] CPP_RESET  = 10'd10;
  localparam logic [6:0] MAXP_RESET = 7'd100;

  // number parsing
  localparam logic [6:0] MAG_MAX = 7'd127;

  // command queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_ON,
    CMD_OFF,
    CMD_PWM,
    CMD_STATUS,
    CMD_UNKNOWN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       negative;
    logic [6:0] magnitude;
  } cmd_t;

  typedef enum logic [2:0] {
    RPL_ON           = 3'd0,
    RPL_OFF          = 3'd1,
    RPL_DUTY_APPLIED = 3'd2,
    RPL_DUTY_SAVED   = 3'd3,
    RPL_STATUS       = 3'd4,
    RPL_RANGE        = 3'd5,
    RPL_UNKNOWN      = 3'd6
  } reply_e;

endpackage

`default_nettype wire

// File: sv/uart_led_pwm_command_parser_unit.sv
// Serial command parser for an LED with PWM dimming.
// Input channel: one received character per transfer on rx_byte_i (in_valid_i/in_stall_o).
// Text up to '!' forms a command: ON, OFF, Status or PWM:<number>; CR and LF are
// dropped and an overlong command starts over empty.
// Output channel: one result per '!' (out_valid_o/out_stall_i) with reply code, LED state,
// stored duty in percent and the PWM compare value (duty times scale while on, else 0).
// Configuration: cfg_valid_i/cfg_ready_o writes register 0 (compare per percent) or
// register 1 (largest accepted duty); cfg_ready_o is always high. Write only while idle.
// Throughput: one character per cycle while the queue is not full. A front end scans
// characters and classifies the command at '!', a two-entry command queue decouples it
// from the back end, which updates LED and duty and registers the result.
// A '!' enters the queue first; the back end then takes it and registers its result.
// Reset: LED off, duty 0, scale 10, duty limit 100, command buffer empty, no result.
// Stall: a stalled result holds; the back end waits, commands collect in the queue,
// and in_stall_o rises only once the queue is full.
`default_nettype none

module uart_led_pwm_command_parser_unit #(
  parameter int unsigned BUFFER_CHARS = 64
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [2:0]                       reply_code_o,
  output logic                             led_on_o,
  output logic [6:0]                       duty_percent_o,
  output logic [15:0]                      compare_value_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [ulpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [ulpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic           push, pop, full, empty;
  ulpc_pkg::cmd_t cmd_in, cmd_out;

  ulpc_front #(
    .BUFFER_CHARS(BUFFER_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  ulpc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  ulpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .empty_i         (empty),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reply_code_o    (reply_code_o),
    .led_on_o        (led_on_o),
    .duty_percent_o  (duty_percent_o),
    .compare_value_o (compare_value_o)
  );

endmodule

`default_nettype wire

// File: sv/ulpc_front.sv
`default_nettype none

module ulpc_front #(
  parameter int unsigned BUFFER_CHARS = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [7:0]        rx_byte_i,
  input  wire               full_i,
  output logic              push_o,
  output ulpc_pkg::cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_CHARS);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BUFFER_CHARS - 1);

  typedef enum logic [1:0] {
    NP_BLANK,
    NP_SIGN,
    NP_DIGIT,
    NP_DONE
  } num_phase_e;

  logic [CNT_W-1:0] count_q, count_d;
  logic [3:0]       flags_q, flags_d;
  num_phase_e       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [6:0]       mag_q, mag_d;

  logic        accept;
  logic        is_bang, is_eol, is_digit, is_blank, is_sign;
  logic [3:0]  digit;
  logic [10:0] mag_ext, mag_sum;
  logic [6:0]  mag_sat;
  logic        ok_on, ok_off, ok_pwm, ok_status;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // byte classes
  assign is_bang  = (rx_byte_i == ulpc_pkg::CH_BANG);
  assign is_eol   = (rx_byte_i == ulpc_pkg::CH_CR) || (rx_byte_i == ulpc_pkg::CH_LF);
  assign is_digit = (rx_byte_i >= ulpc_pkg::CH_ZERO) && (rx_byte_i <= ulpc_pkg::CH_NINE);
  assign is_blank = (rx_byte_i == ulpc_pkg::CH_SPACE) ||
                    ((rx_byte_i >= ulpc_pkg::CH_TAB) && (rx_byte_i <= ulpc_pkg::CH_CR));
  assign is_sign  = (rx_byte_i == ulpc_pkg::CH_PLUS) || (rx_byte_i == ulpc_pkg::CH_MINUS);
  assign digit    = rx_byte_i[3:0];

  // magnitude times ten plus digit, saturating
  assign mag_ext = {4'd0, mag_q};
  assign mag_sum = (mag_ext << 3) + (mag_ext << 1) + {7'd0, digit};
  assign mag_sat = (mag_sum > {4'd0, ulpc_pkg::MAG_MAX}) ? ulpc_pkg::MAG_MAX : mag_sum[6:0];

  // per-position pattern compares
  assign ok_on = ((count_q == CNT_W'(0)) && (rx_byte_i == ulpc_pkg::CH_UC_O)) ||
                 ((count_q == CNT_W'(1)) && (rx_byte_i == ulpc_pkg::CH_UC_N));
  assign ok_off = ((count_q == CNT_W'(0)) && (rx_byte_i == ulpc_pkg::CH_UC_O)) ||
                  ((count_q == CNT_W'(1)) && (rx_byte_i == ulpc_pkg::CH_UC_F)) ||
                  ((count_q == CNT_W'(2)) && (rx_byte_i == ulpc_pkg::CH_UC_F));
  assign ok_pwm = ((count_q == CNT_W'(0)) && (rx_byte_i == ulpc_pkg::CH_UC_P)) ||
                  ((count_q == CNT_W'(1)) && (rx_byte_i == ulpc_pkg::CH_UC_W)) ||
                  ((count_q == CNT_W'(2)) && (rx_byte_i == ulpc_pkg::CH_UC_M)) ||
                  ((count_q == CNT_W'(3)) && (rx_byte_i == ulpc_pkg::CH_COLON));
  assign ok_status = ((count_q == CNT_W'(0)) && (rx_byte_i == ulpc_pkg::CH_UC_S)) ||
                     ((count_q == CNT_W'(1)) && (rx_byte_i == ulpc_pkg::CH_LC_T)) ||
                     ((count_q == CNT_W'(2)) && (rx_byte_i == ulpc_pkg::CH_LC_A)) ||
                     ((count_q == CNT_W'(3)) && (rx_byte_i == ulpc_pkg::CH_LC_T)) ||
                     ((count_q == CNT_W'(4)) && (rx_byte_i == ulpc_pkg::CH_LC_U)) ||
                     ((count_q == CNT_W'(5)) && (rx_byte_i == ulpc_pkg::CH_LC_S));

  // classify the finished command
  always_comb begin
    cmd_o.negative  = neg_q;
    cmd_o.magnitude = mag_q;
    if (flags_q[0] && (count_q == CNT_W'(2))) begin
      cmd_o.kind = ulpc_pkg::CMD_ON;
    end else if (flags_q[1] && (count_q == CNT_W'(3))) begin
      cmd_o.kind = ulpc_pkg::CMD_OFF;
    end else if (flags_q[2] && (count_q >= CNT_W'(4))) begin
      cmd_o.kind = ulpc_pkg::CMD_PWM;
    end else if (flags_q[3] && (count_q == CNT_W'(6))) begin
      cmd_o.kind = ulpc_pkg::CMD_STATUS;
    end else begin
      cmd_o.kind = ulpc_pkg::CMD_UNKNOWN;
    end
  end

  assign push_o = accept && is_bang;

  // command assembly and number scan
  always_comb begin
    count_d = count_q;
    flags_d = flags_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (accept && !is_eol) begin
      if (is_bang || (count_q == LAST_POS)) begin
        count_d = '0;
        flags_d = '1;
        phase_d = NP_BLANK;
        neg_d   = 1'b0;
        mag_d   = '0;
      end else begin
        flags_d = flags_q & {ok_status, ok_pwm || (count_q >= CNT_W'(4)), ok_off, ok_on};
        count_d = count_q + CNT_W'(1);
        if (count_q >= CNT_W'(4)) begin
          unique case (phase_q)
            NP_BLANK: begin
              if (is_blank) begin
                phase_d = NP_BLANK;
              end else if (is_sign) begin
                neg_d   = (rx_byte_i == ulpc_pkg::CH_MINUS);
                phase_d = NP_SIGN;
              end else if (is_digit) begin
                mag_d   = {3'd0, digit};
                phase_d = NP_DIGIT;
              end else begin
                phase_d = NP_DONE;
              end
            end
            NP_SIGN, NP_DIGIT: begin
              if (is_digit) begin
                mag_d   = mag_sat;
                phase_d = NP_DIGIT;
              end else begin
                phase_d = NP_DONE;
              end
            end
            default: begin
              phase_d = NP_DONE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flags_q <= '1;
      phase_q <= NP_BLANK;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      count_q <= count_d;
      flags_q <= flags_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ulpc_cmd_fifo.sv
`default_nettype none

module ulpc_cmd_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  ulpc_pkg::cmd_t  wdata_i,
  input  wire             pop_i,
  output ulpc_pkg::cmd_t  rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned DEPTH = ulpc_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  ulpc_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i)
    else $error("command pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("command popped from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (count_q == $past(count_q) + (PTR_W + 1)'(1)))
    else $error("queue level did not follow a lone push");

endmodule

`default_nettype wire

// File: sv/ulpc_back.sv
`default_nettype none

module ulpc_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [ulpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [ulpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                 empty_i,
  input  ulpc_pkg::cmd_t                      cmd_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [2:0]                          reply_code_o,
  output logic                                led_on_o,
  output logic [6:0]                          duty_percent_o,
  output logic [15:0]                         compare_value_o
);

  logic [9:0]       cpp_q;
  logic [6:0]       maxp_q;
  logic             led_q, led_d;
  logic [6:0]       duty_q, duty_d;
  logic             out_valid_q, out_valid_d;
  ulpc_pkg::reply_e reply_q, reply_d;
  logic [15:0]      compare_q, compare_d;
  logic [16:0]      product;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);

  // command execution
  always_comb begin
    led_d   = led_q;
    duty_d  = duty_q;
    unique case (cmd_i.kind)
      ulpc_pkg::CMD_ON: begin
        led_d   = 1'b1;
        reply_d = ulpc_pkg::RPL_ON;
      end
      ulpc_pkg::CMD_OFF: begin
        led_d   = 1'b0;
        reply_d = ulpc_pkg::RPL_OFF;
      end
      ulpc_pkg::CMD_PWM: begin
        if (cmd_i.negative && (cmd_i.magnitude != '0)) begin
          reply_d = ulpc_pkg::RPL_RANGE;
        end else if (cmd_i.magnitude > maxp_q) begin
          reply_d = ulpc_pkg::RPL_RANGE;
        end else begin
          duty_d  = cmd_i.magnitude;
          reply_d = led_q ? ulpc_pkg::RPL_DUTY_APPLIED : ulpc_pkg::RPL_DUTY_SAVED;
        end
      end
      ulpc_pkg::CMD_STATUS: begin
        reply_d = ulpc_pkg::RPL_STATUS;
      end
      default: begin
        reply_d = ulpc_pkg::RPL_UNKNOWN;
      end
    endcase
  end

  // compare value, saturating at the counter width
  assign product   = 17'(duty_d) * 17'(cpp_q);
  assign compare_d = !led_d ? 16'd0 :
                     (product > 17'h0FFFF) ? 16'hFFFF : product[15:0];

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q       <= ulpc_pkg::CPP_RESET;
      maxp_q      <= ulpc_pkg::MAXP_RESET;
      led_q       <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ulpc_pkg::CFG_COMPARE_PER_PERCENT) begin
          cpp_q <= cfg_data_i[9:0];
        end else if (cfg_index_i == ulpc_pkg::CFG_MAX_PERCENT) begin
          maxp_q <= cfg_data_i[6:0];
        end
      end
      if (pop_o) begin
        led_q  <= led_d;
        duty_q <= duty_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      reply_q   <= reply_d;
      compare_q <= compare_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reply_code_o    = reply_q;
  assign led_on_o        = led_q;
  assign duty_percent_o  = duty_q;
  assign compare_value_o = compare_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !led_on_o) |-> (compare_value_o == 16'd0))
    else $error("compare value driven while led is off");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && (reply_code_o == ulpc_pkg::RPL_ON ||
                                    reply_code_o == ulpc_pkg::RPL_DUTY_APPLIED))
                   |-> led_on_o)
    else $error("reply says led on but led is off");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && (reply_code_o == ulpc_pkg::RPL_OFF ||
                                    reply_code_o == ulpc_pkg::RPL_DUTY_SAVED))
                   |-> !led_on_o)
    else $error("reply says led off but led is on");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_stall_i) |=> $stable(led_q) && $stable(duty_q))
    else $error("led state changed under a stalled result");

endmodule

`default_nettype wire
